// ===== design/assert_macros.svh =====
// Assertion helpers included by the compensation unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_PROP(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("assertion failed");
`define ASSERT_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("assertion failed");
`else
`define ASSERT_PROP(lbl, prop)
`define ASSERT_NEVER(lbl, cond)
`endif
`endif

// ===== design/bpc_pkg.sv =====
`timescale 1ns / 1ps
package bpc_pkg;
	localparam int DivSteps = 32;

	// Register indexes on the configuration port.
	localparam logic [1:0] RegCalibA = 2'd0;
	localparam logic [1:0] RegCalibB = 2'd1;
	localparam logic [1:0] RegCalibC = 2'd2;
	localparam logic [1:0] RegOss    = 2'd3;

	localparam logic [31:0] B6Offset  = 32'd4000;
	localparam logic [31:0] CoefSq    = 32'd3038;
	localparam logic [31:0] CoefLin   = 32'hFFFF_E343;
	localparam logic [31:0] CoefConst = 32'd3791;
	localparam logic [31:0] PScale    = 32'd50000;
	localparam logic [31:0] Half15    = 32'd32768;
	localparam logic [31:0] SignBit   = 32'h8000_0000;

	typedef struct packed {
		logic [15:0] ac1;
		logic [15:0] ac2;
		logic [15:0] ac3;
		logic [15:0] ac4;
		logic [15:0] ac5;
		logic [15:0] ac6;
		logic [15:0] b1;
		logic [15:0] b2;
		logic [15:0] mc;
		logic [15:0] md;
		logic [1:0]  oss;
	} calib_t;

	// Context that travels with an item alongside the arithmetic.
	typedef struct packed {
		logic        vld;
		logic [23:0] up;
		logic [11:0] t;
		logic        err;
		logic        flag;
		logic [31:0] aux;
	} side_t;

	// Arithmetic right shift of a 32-bit word.
	function automatic logic [31:0] asr32(input logic [31:0] v, input logic [4:0] s);
		return $signed(v) >>> s;
	endfunction

	function automatic logic [31:0] sext16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction
endpackage

// ===== design/bpc_udiv.sv =====
`timescale 1ns / 1ps
// Unsigned 32-bit divider, one restoring step per pipeline stage.
module bpc_udiv (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic [31:0]        num,
	input  logic [31:0]        dvs,
	input  bpc_pkg::side_t     side_in,
	output logic [31:0]        quo,
	output bpc_pkg::side_t     side_out
);
	import bpc_pkg::*;

	logic [31:0] rem_s  [0:DivSteps];
	logic [31:0] work_s [0:DivSteps];
	logic [31:0] dvs_s  [0:DivSteps];
	side_t       side_s [0:DivSteps];

	assign rem_s[0]  = '0;
	assign work_s[0] = num;
	assign dvs_s[0]  = dvs;
	assign side_s[0] = side_in;

	// Each stage brings down one dividend bit and shifts in one quotient bit.
	for (genvar k = 0; k < DivSteps; k++) begin : g_step
		logic [32:0] trial;
		logic        ge;
		assign trial = {rem_s[k], work_s[k][31]};
		assign ge = trial >= {1'b0, dvs_s[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				side_s[k+1].vld <= 1'b0;
			end else if (en) begin
				rem_s[k+1]  <= ge ? 32'(trial - {1'b0, dvs_s[k]}) : trial[31:0];
				work_s[k+1] <= {work_s[k][30:0], ge};
				dvs_s[k+1]  <= dvs_s[k];
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign quo      = work_s[DivSteps];
	assign side_out = side_s[DivSteps];
endmodule

// ===== design/bpc_regs.sv =====
`timescale 1ns / 1ps
// Calibration and mode registers behind the APB port.
module bpc_regs (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            psel,
	input  logic            penable,
	input  logic            pwrite,
	input  logic [4:0]      paddr,
	input  logic [63:0]     pwdata,
	output logic [63:0]     prdata,
	output logic            pready,
	output bpc_pkg::calib_t calib
);
	import bpc_pkg::*;

	logic [63:0] word_a_q;
	logic [63:0] word_b_q;
	logic [31:0] word_c_q;
	logic [1:0]  oss_q;
	logic [1:0]  idx;

	assign idx    = paddr[4:3];
	assign pready = 1'b1;

	// Registers are written in the access phase of a write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_a_q <= '0;
			word_b_q <= '0;
			word_c_q <= '0;
			oss_q    <= '0;
		end else if (psel && penable && pwrite) begin
			case (idx)
				RegCalibA: word_a_q <= pwdata;
				RegCalibB: word_b_q <= pwdata;
				RegCalibC: word_c_q <= pwdata[31:0];
				RegOss:    oss_q    <= pwdata[1:0];
				default:   oss_q    <= oss_q;
			endcase
		end
	end

	// Read back.
	always_comb begin
		case (idx)
			RegCalibA: prdata = word_a_q;
			RegCalibB: prdata = word_b_q;
			RegCalibC: prdata = {32'd0, word_c_q};
			RegOss:    prdata = {62'd0, oss_q};
			default:   prdata = '0;
		endcase
	end

	assign calib.ac1 = word_a_q[15:0];
	assign calib.ac2 = word_a_q[31:16];
	assign calib.ac3 = word_a_q[47:32];
	assign calib.ac4 = word_a_q[63:48];
	assign calib.ac5 = word_b_q[15:0];
	assign calib.ac6 = word_b_q[31:16];
	assign calib.b1  = word_b_q[47:32];
	assign calib.b2  = word_b_q[63:48];
	assign calib.mc  = word_c_q[15:0];
	assign calib.md  = word_c_q[31:16];
	assign calib.oss = oss_q;
endmodule

// ===== design/barometric_pressure_compensation_unit.sv =====
`timescale 1ns / 1ps
// Pressure and temperature compensation pipeline. One reading is accepted every
// cycle while the pipeline is not held; it consists of two 32-stage pipelined
// dividers (temperature term and pressure term) plus seventeen arithmetic stages.
// The whole pipeline holds while a finished result is stalled. The user must write
// calibration words and the mode over APB only while the block is idle; the block
// does not enforce this. A zero divisor gives zero outputs with div_error set.
module barometric_pressure_compensation_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] raw_temp,
	input  logic [23:0] raw_pressure_bytes,
	output logic        out_valid,
	input  logic        out_stall,
	output logic signed [11:0] temp_tenths,
	output logic [17:0] pressure_pa,
	output logic        div_error
);
	import bpc_pkg::*;

	calib_t cal;
	logic   en;

	bpc_regs u_regs (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
		.prdata, .pready, .calib(cal)
	);

	// The pipeline moves whenever the output beat is not held.
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	logic        vld_s1, vld_s2, vld_s3, vld_s4;
	logic [15:0] ut_s1;
	logic [23:0] up_s1, up_s2, up_s3, up_s4;
	logic [31:0] prod_s2, x1_s3, den_s3, num_s4, dvs_s4, x1_s4;
	logic        neg_s4, dz_s4;
	logic [31:0] x1_c, mc_sh, quo1, quo2;
	side_t       side_s4, side_d1, side_s5, side_s6, side_s7, side_s8, side_s9;
	side_t       side_s10, side_s11, side_s12, side_d2, side_s13, side_s14;
	side_t       side_s15, side_s16;

	// Stages 1 to 4: raw words, first product, divisor, operand magnitudes.
	assign x1_c  = asr32(prod_s2, 5'd15);
	assign mc_sh = sext16(cal.mc) << 11;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1  <= in_valid;
			ut_s1   <= raw_temp;
			up_s1   <= raw_pressure_bytes >> (4'd8 - {2'd0, cal.oss});
			vld_s2  <= vld_s1;
			up_s2   <= up_s1;
			prod_s2 <= ({16'd0, ut_s1} - {16'd0, cal.ac6}) * {16'd0, cal.ac5};
			vld_s3  <= vld_s2;
			up_s3   <= up_s2;
			x1_s3   <= x1_c;
			den_s3  <= x1_c + sext16(cal.md);
			vld_s4  <= vld_s3;
			up_s4   <= up_s3;
			x1_s4   <= x1_s3;
			num_s4  <= mc_sh[31] ? 32'(-mc_sh) : mc_sh;
			dvs_s4  <= den_s3[31] ? 32'(-den_s3) : den_s3;
			neg_s4  <= mc_sh[31] ^ den_s3[31];
			dz_s4   <= den_s3 == 32'd0;
		end
	end

	always_comb begin
		side_s4      = '0;
		side_s4.vld  = vld_s4;
		side_s4.up   = up_s4;
		side_s4.err  = dz_s4;
		side_s4.flag = neg_s4;
		side_s4.aux  = x1_s4;
	end

	bpc_udiv u_div_temp (
		.clk, .arst_n, .en, .num(num_s4), .dvs(dvs_s4), .side_in(side_s4),
		.quo(quo1), .side_out(side_d1)
	);

	logic [31:0] b5_s5, b6_s5, sqp_s6, ac2b6_s6, ac3b6_s6;
	logic [31:0] sq_s7, x2a_s7, x1c_s7, b2sq_s8, b1sq_s8, x2a_s8, x1c_s8;
	logic [31:0] b3_s9, x3p_s9, b4p_s10, dif_s10, b4_s11, b7_s11;
	logic [31:0] num_s12, dvs_s12;
	logic [31:0] x2_c, b5_c, tt_c, x3_c, b3pre_c, b3_c, x3b_c;
	logic [11:0] tsat_c;
	side_t       side6_c, side12_c;

	// Temperature term and its saturation.
	assign x2_c = side_d1.flag ? 32'(-quo1) : quo1;
	assign b5_c = side_d1.aux + x2_c;
	assign tt_c = asr32(b5_s5 + 32'd8, 5'd4);
	always_comb begin
		if ($signed(tt_c) < -32'sd2048) begin
			tsat_c = 12'h800;
		end else if ($signed(tt_c) > 32'sd2047) begin
			tsat_c = 12'h7FF;
		end else begin
			tsat_c = tt_c[11:0];
		end
	end

	// The saturated temperature joins the context of its item.
	always_comb begin
		side6_c   = side_s5;
		side6_c.t = tsat_c;
	end

	// A zero pressure divisor marks the item, and the sign picks the divide form.
	always_comb begin
		side12_c      = side_s11;
		side12_c.err  = side_s11.err || (b4_s11 == 32'd0);
		side12_c.flag = b7_s11 >= SignBit;
	end

	// Pressure offset and scale terms.
	assign x3_c    = asr32(b2sq_s8, 5'd11) + x2a_s8;
	assign b3pre_c = (((sext16(cal.ac1) << 2) + x3_c) << cal.oss) + 32'd2;
	assign b3_c    = asr32(b3pre_c, 5'd2);
	assign x3b_c   = asr32(x1c_s8 + asr32(b1sq_s8, 5'd16) + 32'd2, 5'd2);

	// Stages 5 to 12: from the temperature quotient to the pressure divider.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s5.vld  <= 1'b0;
			side_s6.vld  <= 1'b0;
			side_s7.vld  <= 1'b0;
			side_s8.vld  <= 1'b0;
			side_s9.vld  <= 1'b0;
			side_s10.vld <= 1'b0;
			side_s11.vld <= 1'b0;
			side_s12.vld <= 1'b0;
		end else if (en) begin
			side_s5  <= side_d1;
			b5_s5    <= b5_c;
			b6_s5    <= b5_c - B6Offset;
			side_s6  <= side6_c;
			sqp_s6   <= b6_s5 * b6_s5;
			ac2b6_s6 <= sext16(cal.ac2) * b6_s5;
			ac3b6_s6 <= sext16(cal.ac3) * b6_s5;
			side_s7  <= side_s6;
			sq_s7    <= asr32(sqp_s6, 5'd12);
			x2a_s7   <= asr32(ac2b6_s6, 5'd11);
			x1c_s7   <= asr32(ac3b6_s6, 5'd13);
			side_s8  <= side_s7;
			b2sq_s8  <= sext16(cal.b2) * sq_s7;
			b1sq_s8  <= sext16(cal.b1) * sq_s7;
			x2a_s8   <= x2a_s7;
			x1c_s8   <= x1c_s7;
			side_s9  <= side_s8;
			b3_s9    <= b3_c;
			x3p_s9   <= x3b_c + Half15;
			side_s10 <= side_s9;
			b4p_s10  <= {16'd0, cal.ac4} * x3p_s9;
			dif_s10  <= {8'd0, side_s9.up} - b3_s9;
			side_s11 <= side_s10;
			b4_s11   <= b4p_s10 >> 15;
			b7_s11   <= dif_s10 * (PScale >> cal.oss);
			side_s12 <= side12_c;
			num_s12  <= (b7_s11 < SignBit) ? (b7_s11 << 1) : b7_s11;
			dvs_s12  <= b4_s11;
		end
	end

	bpc_udiv u_div_press (
		.clk, .arst_n, .en, .num(num_s12), .dvs(dvs_s12), .side_in(side_s12),
		.quo(quo2), .side_out(side_d2)
	);

	logic [31:0] p_s13, p_s14, p_s15, p_s16, x1p_s14, m2_s14, x1m_s15, x2_s15, sum_s16;
	logic [31:0] q_c, pc_c;
	logic [17:0] psat_c;
	logic [11:0] t_q;
	logic [17:0] p_q;
	logic        err_q, vld_q;

	assign q_c  = asr32(p_s13, 5'd8);
	assign pc_c = p_s16 + asr32(sum_s16, 5'd4);
	always_comb begin
		if (pc_c[31]) begin
			psat_c = '0;
		end else if (pc_c > 32'd262143) begin
			psat_c = '1;
		end else begin
			psat_c = pc_c[17:0];
		end
	end

	// Stages 13 to 17: correction polynomial, saturation and the result beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s13.vld <= 1'b0;
			side_s14.vld <= 1'b0;
			side_s15.vld <= 1'b0;
			side_s16.vld <= 1'b0;
			vld_q        <= 1'b0;
		end else if (en) begin
			side_s13 <= side_d2;
			p_s13    <= side_d2.flag ? (quo2 << 1) : quo2;
			side_s14 <= side_s13;
			p_s14    <= p_s13;
			x1p_s14  <= q_c * q_c;
			m2_s14   <= CoefLin * p_s13;
			side_s15 <= side_s14;
			p_s15    <= p_s14;
			x1m_s15  <= x1p_s14 * CoefSq;
			x2_s15   <= asr32(m2_s14, 5'd16);
			side_s16 <= side_s15;
			p_s16    <= p_s15;
			sum_s16  <= asr32(x1m_s15, 5'd16) + x2_s15 + CoefConst;
			vld_q    <= side_s16.vld;
			err_q    <= side_s16.err;
			t_q      <= side_s16.err ? 12'd0 : side_s16.t;
			p_q      <= side_s16.err ? 18'd0 : psat_c;
		end
	end

	assign out_valid   = vld_q;
	assign temp_tenths = $signed(t_q);
	assign pressure_pa = p_q;
	assign div_error   = err_q;

`include "assert_macros.svh"

	`ASSERT_PROP(a_err_zero, out_valid && div_error |-> temp_tenths == 12'sd0 && pressure_pa == 18'd0)
	`ASSERT_PROP(a_take_enters, in_valid && !in_stall |=> vld_s1)
	`ASSERT_PROP(a_hold_result, out_valid && out_stall |=> out_valid && $stable(pressure_pa))
endmodule
